// ===== rtl/core/msdf_pixel_diff_stats_assert.svh =====
// Assertion macros shared by the pixel difference statistics RTL.
`ifndef MSDF_PIXEL_DIFF_STATS_ASSERT_SVH
`define MSDF_PIXEL_DIFF_STATS_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MPDS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mpds assertion failed");

// Next-cycle implication, disabled while reset is low.
`define MPDS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mpds assertion failed");

`endif

// ===== rtl/core/mpds_pkg.sv =====
// Shared types and constants for the pixel difference statistics block.
package mpds_pkg;

    localparam int unsigned MAX_PIXELS_DEF = 65536;
    localparam logic [8:0]  THRESH_RESET   = 9'd26;
    localparam int unsigned FIFO_DEPTH     = 4;
    localparam int unsigned MEAN_W         = 16;
    localparam int unsigned BAD_W          = 15;
    localparam int unsigned TOTAL_W        = 17;

    typedef struct packed {
        logic [7:0] diff;
        logic       bad;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [7:0]         peak_diff;
        logic [MEAN_W-1:0]  mean;
        logic [BAD_W-1:0]   bad_pct;
        logic [TOTAL_W-1:0] total;
    } t_result;

    typedef struct packed {
        logic start;
        logic take;
    } t_div_cmd;

    typedef struct packed {
        logic idle;
        logic done;
    } t_div_stat;

endpackage

// ===== rtl/core/msdf_pixel_diff_stats.sv =====
// Top level of the per-glyph pixel difference statistics block.
// Usage:
//   Input queue: drive one pixel pair (first/second RGB plus last_pixel) and
//   raise push; a transfer happens on a clock edge with push high and full low.
//   Result queue: while empty is low the oldest glyph result (max, mean Q8,
//   bad percent Q8, pixel total) is on the o_ ports; pop high transfers it.
//   Threshold: i_cfg_wdata is written on any edge with i_cfg_we high.
// Throughput: one pixel per cycle while full is low. Closing a glyph starts
//   the two-lane restoring divider; a following glyph that closes before the
//   divider is free stalls in the back end, and the 4-entry queue then fills
//   and raises full.
// Reset: threshold returns to 26, accumulators, queue and result slot clear.
// A stalled result consumer holds the result; the divider waits with the next
//   one, then the back end and finally the input side back up through full.
module msdf_pixel_diff_stats #(
    parameter int unsigned MAX_PIXELS = mpds_pkg::MAX_PIXELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_first_red,
    input  logic [7:0]  i_first_green,
    input  logic [7:0]  i_first_blue,
    input  logic [7:0]  i_second_red,
    input  logic [7:0]  i_second_green,
    input  logic [7:0]  i_second_blue,
    input  logic        i_last_pixel,
    input  logic        pop,
    output logic        empty,
    output logic [7:0]  o_max_difference,
    output logic [15:0] o_mean_difference_q8,
    output logic [14:0] o_bad_percent_q8,
    output logic [16:0] o_pixel_total
);

    localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
    localparam int unsigned DW = CW + 16;

    logic                        front_valid;
    mpds_pkg::t_item             front_item;
    logic                        q_full;
    logic                        q_empty;
    logic                        q_pop;
    mpds_pkg::t_item             q_item;
    mpds_pkg::t_div_cmd          div_cmd;
    mpds_pkg::t_div_stat         div_stat;
    logic [DW-1:0]               dvd_mean;
    logic [DW-1:0]               dvd_bad;
    logic [CW-1:0]               divisor;
    logic [mpds_pkg::MEAN_W-1:0] q_mean;
    logic [mpds_pkg::BAD_W-1:0]  q_bad;
    mpds_pkg::t_result           result;

    mpds_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_first_red    (i_first_red),
        .i_first_green  (i_first_green),
        .i_first_blue   (i_first_blue),
        .i_second_red   (i_second_red),
        .i_second_green (i_second_green),
        .i_second_blue  (i_second_blue),
        .i_last_pixel   (i_last_pixel),
        .o_item_valid   (front_valid),
        .o_item         (front_item),
        .i_item_full    (q_full)
    );

    mpds_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (q_item),
        .o_empty (q_empty)
    );

    mpds_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_empty (q_empty),
        .i_fifo_item  (q_item),
        .o_fifo_pop   (q_pop),
        .o_div_cmd    (div_cmd),
        .i_div_stat   (div_stat),
        .o_dvd_mean   (dvd_mean),
        .o_dvd_bad    (dvd_bad),
        .o_divisor    (divisor),
        .i_q_mean     (q_mean),
        .i_q_bad      (q_bad),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_result     (result)
    );

    mpds_div #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (div_cmd),
        .i_dvd_mean (dvd_mean),
        .i_dvd_bad  (dvd_bad),
        .i_divisor  (divisor),
        .o_stat     (div_stat),
        .o_q_mean   (q_mean),
        .o_q_bad    (q_bad)
    );

    assign o_max_difference     = result.peak_diff;
    assign o_mean_difference_q8 = result.mean;
    assign o_bad_percent_q8     = result.bad_pct;
    assign o_pixel_total        = result.total;

endmodule

// ===== rtl/core/mpds_front.sv =====
// Front end: threshold register, input register, median and difference classification.
module mpds_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [8:0]         i_cfg_wdata,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_first_red,
    input  logic [7:0]         i_first_green,
    input  logic [7:0]         i_first_blue,
    input  logic [7:0]         i_second_red,
    input  logic [7:0]         i_second_green,
    input  logic [7:0]         i_second_blue,
    input  logic               i_last_pixel,
    output logic               o_item_valid,
    output mpds_pkg::t_item    o_item,
    input  logic               i_item_full
);

    function automatic logic [7:0] mid3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] cap;
        hi  = (a > b) ? a : b;
        lo  = (a > b) ? b : a;
        cap = (hi < c) ? hi : c;
        return (lo > cap) ? lo : cap;
    endfunction

    logic [8:0]      r_thresh;
    logic            r_valid;
    mpds_pkg::t_item r_item;
    mpds_pkg::t_item n_item;
    logic [7:0]      med_a;
    logic [7:0]      med_b;
    logic            accept;
    logic            send;

    always_comb begin
        med_a       = mid3(i_first_red, i_first_green, i_first_blue);
        med_b       = mid3(i_second_red, i_second_green, i_second_blue);
        n_item.diff = (med_a > med_b) ? (med_a - med_b) : (med_b - med_a);
        n_item.bad  = ({1'b0, n_item.diff} >= r_thresh);
        n_item.last = i_last_pixel;
    end

    assign send         = r_valid && !i_item_full;
    assign full         = r_valid && i_item_full;
    assign accept       = push && !full;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= mpds_pkg::THRESH_RESET;
            r_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (send) begin
                r_valid <= 1'b0;
            end
        end
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== rtl/core/mpds_fifo.sv =====
// Short queue of classified pixels between front and back.
module mpds_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mpds_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output mpds_pkg::t_item o_item,
    output logic            o_empty
);

    localparam int unsigned PTR_W = $clog2(mpds_pkg::FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(mpds_pkg::FIFO_DEPTH + 1);

    mpds_pkg::t_item  r_mem [mpds_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr;
    logic             rd;

    assign o_full  = (r_count == CNT_W'(mpds_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(mpds_pkg::FIFO_DEPTH - 1)) ? '0
                                                                           : r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(mpds_pkg::FIFO_DEPTH - 1)) ? '0
                                                                           : r_rd_ptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (wr) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== rtl/core/mpds_div.sv =====
// Two-lane restoring divider for the per-glyph mean and bad percentage.
`include "msdf_pixel_diff_stats_assert.svh"

module mpds_div #(
    parameter int unsigned MAX_PIXELS = mpds_pkg::MAX_PIXELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mpds_pkg::t_div_cmd          i_cmd,
    input  logic [$clog2(MAX_PIXELS+1)+15:0] i_dvd_mean,
    input  logic [$clog2(MAX_PIXELS+1)+15:0] i_dvd_bad,
    input  logic [$clog2(MAX_PIXELS+1)-1:0]  i_divisor,
    output mpds_pkg::t_div_stat         o_stat,
    output logic [mpds_pkg::MEAN_W-1:0] o_q_mean,
    output logic [mpds_pkg::BAD_W-1:0]  o_q_bad
);

    localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
    localparam int unsigned DW = CW + 16;
    localparam int unsigned NW = $clog2(DW + 1);
    localparam int unsigned QM = mpds_pkg::MEAN_W;
    localparam int unsigned QB = mpds_pkg::BAD_W;

    typedef enum logic [2:0] {
        DIV_IDLE = 3'b001,
        DIV_RUN  = 3'b010,
        DIV_DONE = 3'b100
    } t_div_state;

    t_div_state       r_state;
    logic [NW-1:0]    r_cnt;
    logic [DW-1:0]    r_dvd_m;
    logic [DW-1:0]    r_dvd_b;
    logic [CW-1:0]    r_rem_m;
    logic [CW-1:0]    r_rem_b;
    logic [CW-1:0]    r_div;
    logic [QM-1:0]    r_q_m;
    logic [QB-1:0]    r_q_b;
    logic [CW:0]      sh_m;
    logic [CW:0]      sh_b;
    logic [CW:0]      sub_m;
    logic [CW:0]      sub_b;
    logic             ge_m;
    logic             ge_b;

    // one quotient bit per lane per cycle, dividend fed MSB first
    always_comb begin
        sh_m  = {r_rem_m, r_dvd_m[DW-1]};
        sh_b  = {r_rem_b, r_dvd_b[DW-1]};
        sub_m = sh_m - {1'b0, r_div};
        sub_b = sh_b - {1'b0, r_div};
        ge_m  = (sh_m >= {1'b0, r_div});
        ge_b  = (sh_b >= {1'b0, r_div});
    end

    assign o_stat.idle = (r_state == DIV_IDLE);
    assign o_stat.done = (r_state == DIV_DONE);
    assign o_q_mean    = r_q_m;
    assign o_q_bad     = r_q_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                DIV_IDLE: begin
                    if (i_cmd.start) begin
                        r_state <= DIV_RUN;
                        r_cnt   <= NW'(DW);
                    end
                end
                DIV_RUN: begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == NW'(1)) begin
                        r_state <= DIV_DONE;
                    end
                end
                DIV_DONE: begin
                    if (i_cmd.take) begin
                        r_state <= DIV_IDLE;
                    end
                end
                default: begin
                    r_state <= DIV_IDLE;
                end
            endcase
        end
        if (r_state == DIV_IDLE && i_cmd.start) begin
            r_dvd_m <= i_dvd_mean;
            r_dvd_b <= i_dvd_bad;
            r_div   <= i_divisor;
            r_rem_m <= '0;
            r_rem_b <= '0;
            r_q_m   <= '0;
            r_q_b   <= '0;
        end else if (r_state == DIV_RUN) begin
            r_dvd_m <= {r_dvd_m[DW-2:0], 1'b0};
            r_dvd_b <= {r_dvd_b[DW-2:0], 1'b0};
            r_rem_m <= ge_m ? sub_m[CW-1:0] : sh_m[CW-1:0];
            r_rem_b <= ge_b ? sub_b[CW-1:0] : sh_b[CW-1:0];
            r_q_m   <= {r_q_m[QM-2:0], ge_m};
            r_q_b   <= {r_q_b[QB-2:0], ge_b};
        end
    end

    `MPDS_ASSERT_IMP(a_start_when_idle, i_clk, i_rst_n, i_cmd.start, r_state == DIV_IDLE)
    `MPDS_ASSERT_IMP(a_take_when_done, i_clk, i_rst_n, i_cmd.take, r_state == DIV_DONE)
    `MPDS_ASSERT_IMP(a_run_has_steps, i_clk, i_rst_n, r_state == DIV_RUN, r_cnt != '0)

endmodule

// ===== rtl/core/mpds_back.sv =====
// Back end: glyph accumulators, divider launch and the result register.
`include "msdf_pixel_diff_stats_assert.svh"

module mpds_back #(
    parameter int unsigned MAX_PIXELS = mpds_pkg::MAX_PIXELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fifo_empty,
    input  mpds_pkg::t_item             i_fifo_item,
    output logic                        o_fifo_pop,
    output mpds_pkg::t_div_cmd          o_div_cmd,
    input  mpds_pkg::t_div_stat         i_div_stat,
    output logic [$clog2(MAX_PIXELS+1)+15:0] o_dvd_mean,
    output logic [$clog2(MAX_PIXELS+1)+15:0] o_dvd_bad,
    output logic [$clog2(MAX_PIXELS+1)-1:0]  o_divisor,
    input  logic [mpds_pkg::MEAN_W-1:0] i_q_mean,
    input  logic [mpds_pkg::BAD_W-1:0]  i_q_bad,
    input  logic                        i_pop,
    output logic                        o_empty,
    output mpds_pkg::t_result           o_result
);

    localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
    localparam int unsigned SW = CW + 8;
    localparam int unsigned TW = mpds_pkg::TOTAL_W;

    logic [7:0]         r_max;
    logic [SW-1:0]      r_sum;
    logic [CW-1:0]      r_bad;
    logic [CW-1:0]      r_cnt;
    logic [7:0]         r_hold_max;
    logic [TW-1:0]      r_hold_total;
    logic               r_out_valid;
    mpds_pkg::t_result  r_out;

    logic [7:0]         n_max;
    logic [SW-1:0]      n_sum;
    logic [CW-1:0]      n_bad;
    logic [CW-1:0]      n_cnt;
    logic [CW+4:0]      bad25;
    logic [CW+TW-1:0]   total_ext;
    logic               close;
    logic               pop_fifo;
    logic               take;

    always_comb begin
        n_max = (i_fifo_item.diff > r_max) ? i_fifo_item.diff : r_max;
        n_sum = r_sum + SW'(i_fifo_item.diff);
        n_bad = r_bad + CW'(i_fifo_item.bad);
        n_cnt = r_cnt + CW'(1);
        // pixel limit closes the glyph even without a last mark
        close = i_fifo_item.last || (n_cnt == CW'(MAX_PIXELS));
        // 25600 = 25 << 10
        bad25 = ({5'b0, n_bad} << 4) + ({5'b0, n_bad} << 3) + {5'b0, n_bad};
        total_ext = {{TW{1'b0}}, n_cnt};
    end

    assign pop_fifo        = !i_fifo_empty && (!close || i_div_stat.idle);
    assign take            = i_div_stat.done && (!r_out_valid || i_pop);
    assign o_fifo_pop      = pop_fifo;
    assign o_div_cmd.start = pop_fifo && close;
    assign o_div_cmd.take  = take;
    assign o_dvd_mean      = {n_sum, 8'b0};
    assign o_dvd_bad       = {1'b0, bad25, 10'b0};
    assign o_divisor       = n_cnt;
    assign o_empty         = !r_out_valid;
    assign o_result        = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= '0;
            r_sum       <= '0;
            r_bad       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop_fifo) begin
                if (close) begin
                    r_max <= '0;
                    r_sum <= '0;
                    r_bad <= '0;
                    r_cnt <= '0;
                end else begin
                    r_max <= n_max;
                    r_sum <= n_sum;
                    r_bad <= n_bad;
                    r_cnt <= n_cnt;
                end
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
        if (pop_fifo && close) begin
            r_hold_max   <= n_max;
            r_hold_total <= total_ext[TW-1:0];
        end
        if (take) begin
            r_out.peak_diff <= r_hold_max;
            r_out.mean      <= i_q_mean;
            r_out.bad_pct   <= i_q_bad;
            r_out.total     <= r_hold_total;
        end
    end

    `MPDS_ASSERT_NXT(a_close_clears, i_clk, i_rst_n, pop_fifo && close, r_cnt == '0)
    `MPDS_ASSERT_NXT(a_open_counts, i_clk, i_rst_n, pop_fifo && !close, r_cnt != '0)
    `MPDS_ASSERT_NXT(a_take_fills_out, i_clk, i_rst_n, take, r_out_valid)

endmodule

// ===== bench/msdf_pixel_diff_stats_tb.sv =====
// Self-checking testbench for the per-glyph pixel difference statistics block.
module msdf_pixel_diff_stats_tb;

    localparam int unsigned SETTLE_CYCLES = 80;
    localparam int unsigned STUCK_LIMIT   = 4000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_LIMIT   = 3000;
    localparam int unsigned PRINT_LIMIT   = 100;

    typedef struct packed {
        logic [7:0] first_red;
        logic [7:0] first_green;
        logic [7:0] first_blue;
        logic [7:0] second_red;
        logic [7:0] second_green;
        logic [7:0] second_blue;
        logic       last;
    } t_pixel_pair;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [8:0]  i_cfg_wdata;
    logic        push;
    logic        full;
    logic [7:0]  i_first_red;
    logic [7:0]  i_first_green;
    logic [7:0]  i_first_blue;
    logic [7:0]  i_second_red;
    logic [7:0]  i_second_green;
    logic [7:0]  i_second_blue;
    logic        i_last_pixel;
    logic        pop;
    logic        empty;
    logic [7:0]  o_max_difference;
    logic [15:0] o_mean_difference_q8;
    logic [14:0] o_bad_percent_q8;
    logic [16:0] o_pixel_total;

    msdf_pixel_diff_stats DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .push                 (push),
        .full                 (full),
        .i_first_red          (i_first_red),
        .i_first_green        (i_first_green),
        .i_first_blue         (i_first_blue),
        .i_second_red         (i_second_red),
        .i_second_green       (i_second_green),
        .i_second_blue        (i_second_blue),
        .i_last_pixel         (i_last_pixel),
        .pop                  (pop),
        .empty                (empty),
        .o_max_difference     (o_max_difference),
        .o_mean_difference_q8 (o_mean_difference_q8),
        .o_bad_percent_q8     (o_bad_percent_q8),
        .o_pixel_total        (o_pixel_total)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // glyph statistics model
    logic [8:0]  thresh_code;
    logic [7:0]  glyph_max;
    logic [23:0] glyph_sum;
    logic [16:0] glyph_bad;
    logic [16:0] glyph_pixels;
    mpds_pkg::t_result pending_stats[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned mismatches    = 0;
    int unsigned stats_checked = 0;
    int unsigned pixels_sent   = 0;
    int unsigned full_stalls   = 0;
    int unsigned thresholds_written = 0;
    int unsigned idle_cycles   = 0;

    function automatic logic [7:0] median3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c < hi)
            hi = c;
        return (lo > hi) ? lo : hi;
    endfunction

    task automatic accumulate_pixel(input t_pixel_pair p);
        logic [7:0] med_a;
        logic [7:0] med_b;
        logic [7:0] diff;
        longint unsigned n;
        mpds_pkg::t_result stats;
        med_a = median3(p.first_red, p.first_green, p.first_blue);
        med_b = median3(p.second_red, p.second_green, p.second_blue);
        diff  = (med_a > med_b) ? med_a - med_b : med_b - med_a;
        if (diff > glyph_max)
            glyph_max = diff;
        glyph_sum = glyph_sum + diff;
        if ({1'b0, diff} >= thresh_code)
            glyph_bad = glyph_bad + 1;
        glyph_pixels = glyph_pixels + 1;
        // a glyph that hits the pixel limit closes itself
        if (p.last || glyph_pixels >= mpds_pkg::MAX_PIXELS_DEF) begin
            n = glyph_pixels;
            stats.peak_diff = glyph_max;
            stats.mean      = mpds_pkg::MEAN_W'((longint'(glyph_sum) * 256) / n);
            stats.bad_pct   = mpds_pkg::BAD_W'((longint'(glyph_bad) * 25600) / n);
            stats.total     = glyph_pixels;
            pending_stats.push_back(stats);
            glyph_max    = '0;
            glyph_sum    = '0;
            glyph_bad    = '0;
            glyph_pixels = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        if (mismatches < PRINT_LIMIT)
            $display("MISMATCH %s: got %0d, expected %0d (result %0d, t=%0t)",
                     what, got, want, stats_checked, $realtime);
        mismatches++;
    endtask

    // result side: random stalls plus an on-demand long hold-off
    initial begin
        int unsigned hold_granted;
        int unsigned hold_left;
        hold_granted = 0;
        hold_left    = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_granted != hold_requests) begin
                hold_granted = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        mpds_pkg::t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_stats.size() == 0) begin
                report_mismatch("unexpected result, pixel_total", o_pixel_total, 0);
            end else begin
                want = pending_stats.pop_front();
                if (o_max_difference !== want.peak_diff)
                    report_mismatch("max_difference", o_max_difference, want.peak_diff);
                if (o_mean_difference_q8 !== want.mean)
                    report_mismatch("mean_difference_q8", o_mean_difference_q8, want.mean);
                if (o_bad_percent_q8 !== want.bad_pct)
                    report_mismatch("bad_percent_q8", o_bad_percent_q8, want.bad_pct);
                if (o_pixel_total !== want.total)
                    report_mismatch("pixel_total", o_pixel_total, want.total);
                stats_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STUCK_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results pending",
                     idle_cycles, pending_stats.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic send_pixel(input t_pixel_pair p);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push           <= 1'b1;
        i_first_red    <= p.first_red;
        i_first_green  <= p.first_green;
        i_first_blue   <= p.first_blue;
        i_second_red   <= p.second_red;
        i_second_green <= p.second_green;
        i_second_blue  <= p.second_blue;
        i_last_pixel   <= p.last;
        @(posedge i_clk);
        while (full) begin
            full_stalls++;
            @(posedge i_clk);
        end
        accumulate_pixel(p);
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (pending_stats.size() != 0)
            @(negedge i_clk);
        // non-closing pixels may still be in flight
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [8:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        thresh_code = value;
        thresholds_written++;
    endtask

    function automatic t_pixel_pair make_pair(logic [7:0] fr, logic [7:0] fg, logic [7:0] fb,
                                              logic [7:0] sr, logic [7:0] sg, logic [7:0] sb,
                                              logic last);
        t_pixel_pair p;
        p = {fr, fg, fb, sr, sg, sb, last};
        return p;
    endfunction

    // three channels in random order whose median is m
    function automatic logic [23:0] channels_with_median(logic [7:0] m);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'($urandom_range(m, 0));
        hi = 8'($urandom_range(255, m));
        case ($urandom_range(5))
            0: return {lo, m, hi};
            1: return {lo, hi, m};
            2: return {m, lo, hi};
            3: return {m, hi, lo};
            4: return {hi, lo, m};
            default: return {hi, m, lo};
        endcase
    endfunction

    function automatic t_pixel_pair pixel_with_diff(int unsigned d, logic last);
        logic [7:0]  med_a;
        logic [7:0]  med_b;
        logic [7:0]  swap;
        t_pixel_pair p;
        med_a = 8'($urandom_range(255, d));
        med_b = med_a - 8'(d);
        if ($urandom_range(1)) begin
            swap  = med_a;
            med_a = med_b;
            med_b = swap;
        end
        p = {channels_with_median(med_a), channels_with_median(med_b), last};
        return p;
    endfunction

    function automatic t_pixel_pair random_pixel(logic last);
        int t;
        int d;
        t_pixel_pair p;
        case ($urandom_range(19))
            0, 1, 2, 3, 4, 5, 6, 7: begin
                p = {24'($urandom), 24'($urandom), last};
            end
            8, 9, 10, 11, 12, 13, 14: begin
                // land right around the bad threshold
                t = (thresh_code > 255) ? 255 : int'(thresh_code);
                d = t + int'($urandom_range(3)) - 2;
                if (d < 0)
                    d = 0;
                if (d > 255)
                    d = 255;
                p = pixel_with_diff(d, last);
            end
            15, 16, 17: p = pixel_with_diff($urandom_range(255), last);
            default:    p = pixel_with_diff($urandom_range(1) ? 255 : 0, last);
        endcase
        return p;
    endfunction

    // reset threshold of 26: pixels just below, at and far above it,
    // median taken from each channel position
    task automatic test_reset_threshold();
        send_pixel(make_pair(8'd77, 8'd77, 8'd77, 8'd3, 8'd77, 8'd200, 1'b1));
        send_pixel(make_pair(8'd60, 8'd200, 8'd10, 8'd34, 8'd0, 8'd255, 1'b0));
        send_pixel(make_pair(8'd5, 8'd30, 8'd90, 8'd90, 8'd55, 8'd1, 1'b0));
        send_pixel(make_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0));
        send_pixel(make_pair(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b0));
        send_pixel(make_pair(8'd200, 8'd100, 8'd150, 8'd150, 8'd250, 8'd90, 1'b1));
        send_pixel(make_pair(8'hAA, 8'h55, 8'hF0, 8'h0F, 8'h55, 8'hAA, 1'b1));
    endtask

    task automatic test_threshold_extremes();
        // zero: every pixel is bad, even with no difference
        write_threshold(9'd0);
        send_pixel(make_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_pixel(make_pair(8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0));
        send_pixel(make_pair(8'd9, 8'd12, 8'd40, 8'd12, 8'd12, 8'd12, 1'b1));
        // above full scale: nothing can be bad
        write_threshold(9'd256);
        send_pixel(make_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0));
        send_pixel(make_pair(8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        write_threshold(9'h1FF);
        send_pixel(make_pair(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1));
        // full scale: only a 255 difference counts
        write_threshold(9'd255);
        send_pixel(make_pair(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0));
        send_pixel(make_pair(8'hFE, 8'hFE, 8'hFE, 8'h00, 8'h00, 8'h00, 1'b0));
        send_pixel(make_pair(8'h00, 8'h01, 8'h02, 8'h01, 8'h01, 8'h01, 1'b1));
    endtask

    task automatic test_random_glyphs(input int unsigned n_items);
        int unsigned sent;
        int unsigned chunk;
        int unsigned glyph_left;
        logic        last;
        sent = 0;
        while (sent < n_items) begin
            chunk = (n_items - sent > 120) ? 120 : n_items - sent;
            case ($urandom_range(9))
                0:       write_threshold(9'($urandom_range(511, 256)));
                1, 2:    write_threshold(9'($urandom_range(255, 65)));
                default: write_threshold(9'($urandom_range(64)));
            endcase
            glyph_left = 0;
            for (int i = 0; i < chunk; i++) begin
                if (glyph_left == 0) begin
                    case ($urandom_range(19))
                        0:       glyph_left = $urandom_range(150, 41);
                        1, 2, 3, 4, 5: glyph_left = $urandom_range(40, 9);
                        default: glyph_left = $urandom_range(8, 1);
                    endcase
                end
                glyph_left--;
                last = (glyph_left == 0) || (i == chunk - 1);
                if (last)
                    glyph_left = 0;
                send_pixel(random_pixel(last));
            end
            sent += chunk;
        end
    endtask

    // results back up behind a long hold-off until the input side stalls
    task automatic test_backpressure();
        write_threshold(mpds_pkg::THRESH_RESET);
        hold_requests++;
        repeat (40) begin
            if ($urandom_range(3) == 0)
                send_pixel(random_pixel(1'b0));
            send_pixel(random_pixel(1'b1));
        end
        wait_idle();
        repeat (12) send_pixel(random_pixel($urandom_range(2) == 0));
        send_pixel(random_pixel(1'b1));
    endtask

    initial begin
        int unsigned k;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        push           = 1'b0;
        i_first_red    = '0;
        i_first_green  = '0;
        i_first_blue   = '0;
        i_second_red   = '0;
        i_second_green = '0;
        i_second_blue  = '0;
        i_last_pixel   = 1'b0;
        thresh_code    = mpds_pkg::THRESH_RESET;
        glyph_max      = '0;
        glyph_sum      = '0;
        glyph_bad      = '0;
        glyph_pixels   = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_threshold();
        test_threshold_extremes();

        send_idle_pct = 19;
        recv_idle_pct = 88;
        test_random_glyphs(490);
        send_idle_pct = 88;
        recv_idle_pct = 19;
        test_random_glyphs(490);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_glyphs(490);
        test_backpressure();

        push <= 1'b0;
        k = 0;
        while (k < DRAIN_LIMIT && pending_stats.size() != 0) begin
            @(negedge i_clk);
            k++;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (pending_stats.size() != 0)
            report_mismatch("glyph results never delivered", 0, pending_stats.size());

        $display("Covered %0d pixel transfers, %0d glyph results, %0d threshold writes,",
                 pixels_sent, stats_checked, thresholds_written);
        $display("threshold edge values and %0d cycles of input held off by a full block.",
                 full_stalls);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/mpds_pkg.sv
rtl/core/mpds_front.sv
rtl/core/mpds_fifo.sv
rtl/core/mpds_div.sv
rtl/core/mpds_back.sv
rtl/core/msdf_pixel_diff_stats.sv
bench/msdf_pixel_diff_stats_tb.sv
